>>> rtl/sorted_array_priority_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted array priority queue unit
// Two macros for concurrent checks, both removed when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define SAPQ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// When the first expression holds, the second must hold in the next cycle.
`define SAPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SAPQ_ASSERT(lbl, clk, rstn, prop, msg)
`define SAPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared widths, operation and status codes, and the command and status
// structs between the queue controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sapq_pkg;

	// Field widths of the stream beats.
	localparam int unsigned OP_W       = 2;
	localparam int unsigned ITEM_W     = 32;
	localparam int unsigned PRIO_W     = 32;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned ENTRY_W    = ITEM_W + PRIO_W;
	localparam int unsigned S_TDATA_W  = 72;
	localparam int unsigned M_TDATA_W  = 40;

	// Operation codes; code three is a no-op.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input beat
		logic stat_load;  // latch the result status
		logic rd_en;      // issue an array read
		logic rd_top;     // read the top entry instead of the one below the hole
		logic wr_en;      // write the array at the hole index
		logic wr_new;     // write the new pair instead of the entry just read
		logic j_dec;      // move the hole index down by one
		logic cnt_inc;
		logic cnt_dec;
		logic top_load;   // capture the item just read from the top
		logic out_load;   // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            full;
		logic            j_zero;
		logic            j_one;
		logic            shift;     // entry read has priority at or above the new one
		logic            out_free;  // output register can take a result this cycle
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/sapq_ram.sv
// ----------------------------------------------------------------------------
// sapq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/sapq_datapath.sv
// ----------------------------------------------------------------------------
// sapq_datapath
// Entry array, count, hole index, priority compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_array_priority_queue_unit_macros.svh"

module sapq_datapath
	import sapq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = $clog2(DEPTH),
	localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata
);

	logic        [OP_W-1:0]     op_q;
	logic        [ITEM_W-1:0]   item_q;
	logic signed [PRIO_W-1:0]   prio_q;
	logic        [AW-1:0]       j_q;
	logic        [CW-1:0]       cnt_q;
	logic        [STATUS_W-1:0] stat_q;
	logic        [ITEM_W-1:0]   top_q;
	logic                       m_tvalid_q;
	logic        [ITEM_W-1:0]   out_item_q;
	logic        [STATUS_W-1:0] out_status_q;
	logic        [COUNT_W-1:0]  out_count_q;

	logic        [AW-1:0]       j_next;
	logic        [AW-1:0]       top_addr;
	logic        [AW-1:0]       rd_addr;
	logic        [ENTRY_W-1:0]  rd_data;
	logic        [ENTRY_W-1:0]  wr_data;
	logic signed [PRIO_W-1:0]   rd_prio;
	logic        [CW+COUNT_W-1:0] cnt_ext;
	logic        [CW-1:0]       cnt_m1;

	// Array of (priority, item) pairs, priority in the upper half.
	sapq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(j_q),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Address and data selection.
	always_comb begin
		cnt_m1   = cnt_q - CW'(1);
		top_addr = cnt_m1[AW-1:0];
		j_next   = cmd.j_dec ? (j_q - AW'(1)) : j_q;
		rd_addr  = cmd.rd_top ? top_addr : (j_next - AW'(1));
		wr_data  = cmd.wr_new ? {prio_q, item_q} : rd_data;
		rd_prio  = rd_data[ENTRY_W-1:ITEM_W];
		cnt_ext  = {{COUNT_W{1'b0}}, cnt_q};
	end

	// Status toward the controller.
	always_comb begin
		sts.op       = op_q;
		sts.empty    = (cnt_q == '0);
		sts.full     = (cnt_q == CW'(DEPTH));
		sts.j_zero   = (j_q == '0);
		sts.j_one    = (j_q == AW'(1));
		sts.shift    = (rd_prio >= prio_q);
		sts.out_free = !m_tvalid_q || m_tready;
	end

	// Input capture, hole index and result fields.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= s_tdata[OP_W-1:0];
			item_q <= s_tdata[OP_W+ITEM_W-1:OP_W];
			prio_q <= s_tdata[OP_W+ITEM_W+PRIO_W-1:OP_W+ITEM_W];
			j_q    <= cnt_q[AW-1:0];
			top_q  <= '0;
		end else begin
			if (cmd.j_dec) begin
				j_q <= j_next;
			end
			if (cmd.top_load) begin
				top_q <= rd_data[ITEM_W-1:0];
			end
		end
		if (cmd.stat_load) begin
			if (op_q == OP_INSERT) begin
				stat_q <= sts.full ? ST_FULL : ST_OK;
			end else if (op_q inside {OP_DELETE, OP_PEEK}) begin
				stat_q <= sts.empty ? ST_EMPTY : ST_OK;
			end else begin
				stat_q <= ST_OK;
			end
		end
		if (cmd.out_load) begin
			out_item_q   <= top_q;
			out_status_q <= stat_q;
			out_count_q  <= cnt_ext[COUNT_W-1:0];
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_m1;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_count_q, out_status_q, out_item_q};

	`SAPQ_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CW'(DEPTH), "entry count above depth")
	`SAPQ_ASSERT(a_rw_apart, clk, arst_n, !(cmd.wr_en && cmd.rd_en) || (j_q != rd_addr), "read and write hit one entry")

endmodule

`default_nettype wire

>>> rtl/sapq_ctrl.sv
// ----------------------------------------------------------------------------
// sapq_ctrl
// Controller state machine: decodes an operation and steps the datapath
// through the insert shift walk or the top read, then hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_array_priority_queue_unit_macros.svh"

module sapq_ctrl
	import sapq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [5:0] {
		IDLE     = 6'b000001,
		DECODE   = 6'b000010,
		INS_CMP  = 6'b000100,
		INS_NEW  = 6'b001000,
		TOP_WAIT = 6'b010000,
		FINISH   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = DECODE;
				end
			end
			DECODE: begin
				cmd.stat_load = 1'b1;
				if (sts.op == OP_INSERT && !sts.full) begin
					if (sts.j_zero) begin
						state_d = INS_NEW;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = INS_CMP;
					end
				end else if (sts.op inside {OP_DELETE, OP_PEEK} && !sts.empty) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_top = 1'b1;
					state_d    = TOP_WAIT;
				end else begin
					state_d = FINISH;
				end
			end
			INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.shift) begin
					// Move the entry up into the hole and look one lower.
					cmd.j_dec = 1'b1;
					if (sts.j_one) begin
						state_d = INS_NEW;
					end else begin
						cmd.rd_en = 1'b1;
					end
				end else begin
					cmd.wr_new  = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = FINISH;
				end
			end
			INS_NEW: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_new  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = FINISH;
			end
			TOP_WAIT: begin
				cmd.top_load = 1'b1;
				cmd.cnt_dec  = (sts.op == OP_DELETE);
				state_d      = FINISH;
			end
			FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SAPQ_ASSERT_NEXT(a_one_beat, clk, arst_n, s_tvalid && s_tready, !s_tready, "beat taken while busy")
	`SAPQ_ASSERT(a_cnt_excl, clk, arst_n, !(cmd.cnt_inc && cmd.cnt_dec), "count raised and lowered together")
	`SAPQ_ASSERT(a_shift_src, clk, arst_n, !(cmd.wr_en && !cmd.wr_new) || $past(cmd.rd_en), "shift without a fresh read")

endmodule

`default_nettype wire

>>> rtl/sorted_array_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Priority queue of up to DEPTH (item, priority) pairs kept in a RAM sorted
// by ascending priority; insert, delete top and peek top.
// ----------------------------------------------------------------------------
// Usage: one operation arrives per beat on the s_ channel and exactly one
// result beat leaves on the m_ channel for it. Operations are insert, delete
// top and peek top; equal priorities leave first in, first out. Delete or
// peek on an empty queue returns status empty; insert into a full queue drops
// the pair and returns status full. Every result carries the entry count.
// Sequence: a rejected operation or a no-op goes from DECODE to FINISH,
// where the result is loaded into the output register once it is free; a
// delete or peek first captures the top entry in TOP_WAIT; an insert moves
// up each stored entry that makes room in INS_CMP, with one RAM read and
// one RAM write per cycle, then writes the pair there or in INS_NEW. The
// next beat is accepted on the cycle after the result is loaded.
// Reset clears the entry count and the output valid flag; RAM contents are
// not cleared. When the receiver stalls, the finished result waits in the
// output register and the next operation is still taken and worked on; it
// holds its result until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_priority_queue_unit
	import sapq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// op[1:0], item[33:2], priority_req[65:34], zero pad [71:66]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// item_out[31:0], status[33:32], count[38:34], zero pad [39]
	output logic      [M_TDATA_W-1:0] m_tdata
);

	cmd_t cmd;
	sts_t sts;

	sapq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sapq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire
